[design/hpm_pkg.sv]
// shared types, constants and arithmetic helpers for the 2d point mapper
package hpm_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int PERSP_FRAC = 30;
  localparam int COEF_W     = 32;
  localparam int PT_W       = COORD_W + 1;
  localparam int PROD_W     = PT_W + COEF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int NUM_W      = SUM_W + PERSP_FRAC;
  localparam int QS_W       = NUM_W + 1;
  localparam int DIFF_W     = QS_W + 1;
  localparam int DIV_STEPS  = NUM_W;
  localparam int LANES      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W  = 4 * COORD_W;
  localparam int OUT_DATA_W = 2 * COORD_W;

  // divider lanes
  localparam int LANE_X1 = 0;
  localparam int LANE_Y1 = 1;
  localparam int LANE_X2 = 2;
  localparam int LANE_Y2 = 3;

  typedef enum logic [2:0] {
    FORM_IDENT  = 3'd0,
    FORM_TRANS  = 3'd1,
    FORM_RIGID  = 3'd2,
    FORM_AFFINE = 3'd3,
    FORM_PROJ   = 3'd4
  } form_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORM    = 3'd0,
    CFG_LIN_XX  = 3'd1,
    CFG_LIN_XY  = 3'd2,
    CFG_LIN_YX  = 3'd3,
    CFG_LIN_YY  = 3'd4,
    CFG_OFFSET  = 3'd5,
    CFG_PERSP   = 3'd6,
    CFG_PERSP_W = 3'd7
  } cfg_idx_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PT_W-1:0]    pt_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic        [NUM_W-1:0]   num_t;
  typedef logic        [SUM_W-1:0]   den_t;
  typedef logic signed [QS_W-1:0]    qs_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  localparam coord_t COORD_MAX = coord_t'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam coord_t COORD_MIN = coord_t'(~COORD_MAX);

  typedef struct packed {
    form_t form;
    coef_t lin_xx;
    coef_t lin_xy;
    coef_t lin_yx;
    coef_t lin_yy;
    coef_t off_x;
    coef_t off_y;
    coef_t persp_g;
    coef_t persp_h;
    coef_t persp_w;
  } cfg_t;

  // per-item control and the results of the non-projective forms
  typedef struct packed {
    form_t  form;
    logic   func;
    logic   inf;
    coord_t rx;
    coord_t ry;
    logic   rsat;
  } side_t;

  typedef struct packed {
    den_t rem;
    num_t nq;
    den_t den;
    logic neg;
  } div_lane_t;

  typedef div_lane_t [LANES-1:0] lane_arr_t;

  typedef struct packed {
    coord_t val;
    logic   flag;
  } sat_t;

  function automatic sat_t sat_coord(input diff_t v);
    logic [DIFF_W-COORD_W:0] top;
    sat_t r;
    top = v[DIFF_W-1:COORD_W-1];
    if (top == '0 || top == '1) begin
      r.val  = v[COORD_W-1:0];
      r.flag = 1'b0;
    end else begin
      r.val  = v[DIFF_W-1] ? COORD_MIN : COORD_MAX;
      r.flag = 1'b1;
    end
    return r;
  endfunction

  function automatic prod_t smul(input pt_t a, input coef_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic den_t mag(input sum_t v);
    return den_t'(v[SUM_W-1] ? -v : v);
  endfunction

endpackage

[design/hpm_front.sv]
// front stages: point select, products, sums, divider setup
module hpm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ce,
  input  logic                  valid_i,
  input  logic                  func_i,
  input  hpm_pkg::coord_t       x_i,
  input  hpm_pkg::coord_t       y_i,
  input  hpm_pkg::coord_t       dx_i,
  input  hpm_pkg::coord_t       dy_i,
  input  hpm_pkg::cfg_t         cfg_i,
  output logic                  valid_o,
  output hpm_pkg::side_t        side_o,
  output hpm_pkg::lane_arr_t    lanes_o
);

  // stage 1
  logic            v1_r;
  hpm_pkg::side_t  s1_r, s1_nxt;
  hpm_pkg::pt_t    p1x_r, p1y_r, p2x_r, p2y_r, p1x_nxt, p1y_nxt;
  // stage 2
  logic            v2_r;
  hpm_pkg::side_t  s2_r;
  hpm_pkg::prod_t  m_r [12];
  // stage 3
  logic            v3_r;
  hpm_pkg::side_t  s3_r;
  hpm_pkg::sum_t   n1x_r, n1y_r, z1_r, n2x_r, n2y_r, z2_r;
  hpm_pkg::sum_t   n1x_nxt, n1y_nxt, z1_nxt, n2x_nxt, n2y_nxt, z2_nxt;
  // stage 4
  logic            v4_r;
  hpm_pkg::side_t  s4_r, s4_nxt;
  hpm_pkg::lane_arr_t l4_r, l4_nxt;

  hpm_pkg::pt_t    xe, ye, dxe, dye;
  hpm_pkg::sat_t   tsx, tsy, asx, asy;
  hpm_pkg::sum_t   offx_s, offy_s, w_s;
  logic            add_off;

  always_comb begin
    xe  = hpm_pkg::pt_t'(x_i);
    ye  = hpm_pkg::pt_t'(y_i);
    dxe = hpm_pkg::pt_t'(dx_i);
    dye = hpm_pkg::pt_t'(dy_i);
    if (!func_i) begin
      p1x_nxt = xe;
      p1y_nxt = ye;
    end else if (cfg_i.form == hpm_pkg::FORM_PROJ) begin
      p1x_nxt = xe + dxe;
      p1y_nxt = ye + dye;
    end else begin
      p1x_nxt = dxe;
      p1y_nxt = dye;
    end
    tsx = hpm_pkg::sat_coord(hpm_pkg::diff_t'(xe + hpm_pkg::pt_t'(cfg_i.off_x)));
    tsy = hpm_pkg::sat_coord(hpm_pkg::diff_t'(ye + hpm_pkg::pt_t'(cfg_i.off_y)));
    s1_nxt.form = cfg_i.form;
    s1_nxt.func = func_i;
    s1_nxt.inf  = 1'b0;
    s1_nxt.rx   = '0;
    s1_nxt.ry   = '0;
    s1_nxt.rsat = 1'b0;
    case (cfg_i.form)
      hpm_pkg::FORM_IDENT: begin
        s1_nxt.rx = func_i ? dx_i : x_i;
        s1_nxt.ry = func_i ? dy_i : y_i;
      end
      hpm_pkg::FORM_TRANS: begin
        s1_nxt.rx   = func_i ? dx_i : tsx.val;
        s1_nxt.ry   = func_i ? dy_i : tsy.val;
        s1_nxt.rsat = !func_i && (tsx.flag || tsy.flag);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (ce) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (ce) begin
      s1_r  <= s1_nxt;
      p1x_r <= p1x_nxt;
      p1y_r <= p1y_nxt;
      p2x_r <= hpm_pkg::pt_t'(x_i);
      p2y_r <= hpm_pkg::pt_t'(y_i);
    end
  end

  // stage 2: twelve products
  always_ff @(posedge clk) begin
    if (ce) begin
      s2_r   <= s1_r;
      m_r[0]  <= hpm_pkg::smul(p1x_r, cfg_i.lin_xx);
      m_r[1]  <= hpm_pkg::smul(p1y_r, cfg_i.lin_xy);
      m_r[2]  <= hpm_pkg::smul(p1x_r, cfg_i.lin_yx);
      m_r[3]  <= hpm_pkg::smul(p1y_r, cfg_i.lin_yy);
      m_r[4]  <= hpm_pkg::smul(p1x_r, cfg_i.persp_g);
      m_r[5]  <= hpm_pkg::smul(p1y_r, cfg_i.persp_h);
      m_r[6]  <= hpm_pkg::smul(p2x_r, cfg_i.lin_xx);
      m_r[7]  <= hpm_pkg::smul(p2y_r, cfg_i.lin_xy);
      m_r[8]  <= hpm_pkg::smul(p2x_r, cfg_i.lin_yx);
      m_r[9]  <= hpm_pkg::smul(p2y_r, cfg_i.lin_yy);
      m_r[10] <= hpm_pkg::smul(p2x_r, cfg_i.persp_g);
      m_r[11] <= hpm_pkg::smul(p2y_r, cfg_i.persp_h);
    end
  end

  // stage 3: numerators and denominators
  always_comb begin
    offx_s  = hpm_pkg::sum_t'(cfg_i.off_x) <<< hpm_pkg::FRAC_W;
    offy_s  = hpm_pkg::sum_t'(cfg_i.off_y) <<< hpm_pkg::FRAC_W;
    w_s     = hpm_pkg::sum_t'(cfg_i.persp_w) <<< hpm_pkg::PERSP_FRAC;
    // a linear displacement takes no offset
    add_off = !(s2_r.func && (s2_r.form == hpm_pkg::FORM_RIGID ||
                              s2_r.form == hpm_pkg::FORM_AFFINE));
    n1x_nxt = hpm_pkg::sum_t'(m_r[0]) + hpm_pkg::sum_t'(m_r[1]) + (add_off ? offx_s : '0);
    n1y_nxt = hpm_pkg::sum_t'(m_r[2]) + hpm_pkg::sum_t'(m_r[3]) + (add_off ? offy_s : '0);
    z1_nxt  = hpm_pkg::sum_t'(m_r[4]) + hpm_pkg::sum_t'(m_r[5]) + w_s;
    n2x_nxt = hpm_pkg::sum_t'(m_r[6]) + hpm_pkg::sum_t'(m_r[7]) + offx_s;
    n2y_nxt = hpm_pkg::sum_t'(m_r[8]) + hpm_pkg::sum_t'(m_r[9]) + offy_s;
    z2_nxt  = hpm_pkg::sum_t'(m_r[10]) + hpm_pkg::sum_t'(m_r[11]) + w_s;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_r  <= s2_r;
      n1x_r <= n1x_nxt;
      n1y_r <= n1y_nxt;
      z1_r  <= z1_nxt;
      n2x_r <= n2x_nxt;
      n2y_r <= n2y_nxt;
      z2_r  <= z2_nxt;
    end
  end

  // stage 4: affine result, zero check, divider operands
  always_comb begin
    asx    = hpm_pkg::sat_coord(hpm_pkg::diff_t'(n1x_r >>> hpm_pkg::FRAC_W));
    asy    = hpm_pkg::sat_coord(hpm_pkg::diff_t'(n1y_r >>> hpm_pkg::FRAC_W));
    s4_nxt = s3_r;
    if (s3_r.form == hpm_pkg::FORM_RIGID || s3_r.form == hpm_pkg::FORM_AFFINE) begin
      s4_nxt.rx   = asx.val;
      s4_nxt.ry   = asy.val;
      s4_nxt.rsat = asx.flag || asy.flag;
    end
    s4_nxt.inf = (s3_r.form == hpm_pkg::FORM_PROJ) &&
                 (z1_r == '0 || (s3_r.func && z2_r == '0));
    l4_nxt[hpm_pkg::LANE_X1].nq  = {hpm_pkg::mag(n1x_r), {hpm_pkg::PERSP_FRAC{1'b0}}};
    l4_nxt[hpm_pkg::LANE_X1].den = hpm_pkg::mag(z1_r);
    l4_nxt[hpm_pkg::LANE_X1].neg = n1x_r[hpm_pkg::SUM_W-1] ^ z1_r[hpm_pkg::SUM_W-1];
    l4_nxt[hpm_pkg::LANE_Y1].nq  = {hpm_pkg::mag(n1y_r), {hpm_pkg::PERSP_FRAC{1'b0}}};
    l4_nxt[hpm_pkg::LANE_Y1].den = hpm_pkg::mag(z1_r);
    l4_nxt[hpm_pkg::LANE_Y1].neg = n1y_r[hpm_pkg::SUM_W-1] ^ z1_r[hpm_pkg::SUM_W-1];
    l4_nxt[hpm_pkg::LANE_X2].nq  = {hpm_pkg::mag(n2x_r), {hpm_pkg::PERSP_FRAC{1'b0}}};
    l4_nxt[hpm_pkg::LANE_X2].den = hpm_pkg::mag(z2_r);
    l4_nxt[hpm_pkg::LANE_X2].neg = n2x_r[hpm_pkg::SUM_W-1] ^ z2_r[hpm_pkg::SUM_W-1];
    l4_nxt[hpm_pkg::LANE_Y2].nq  = {hpm_pkg::mag(n2y_r), {hpm_pkg::PERSP_FRAC{1'b0}}};
    l4_nxt[hpm_pkg::LANE_Y2].den = hpm_pkg::mag(z2_r);
    l4_nxt[hpm_pkg::LANE_Y2].neg = n2y_r[hpm_pkg::SUM_W-1] ^ z2_r[hpm_pkg::SUM_W-1];
    for (int i = 0; i < hpm_pkg::LANES; i++) begin
      l4_nxt[i].rem = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_r <= s4_nxt;
      l4_r <= l4_nxt;
    end
  end

  assign valid_o = v4_r;
  assign side_o  = s4_r;
  assign lanes_o = l4_r;

endmodule

[design/hpm_div_step.sv]
// one restoring-division step for all divider lanes
module hpm_div_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ce,
  input  logic               valid_i,
  input  hpm_pkg::side_t     side_i,
  input  hpm_pkg::lane_arr_t lanes_i,
  output logic               valid_o,
  output hpm_pkg::side_t     side_o,
  output hpm_pkg::lane_arr_t lanes_o
);

  logic               v_r;
  hpm_pkg::side_t     side_r;
  hpm_pkg::lane_arr_t lanes_r, lanes_nxt;
  logic [hpm_pkg::SUM_W:0] trial [hpm_pkg::LANES];
  logic [hpm_pkg::SUM_W:0] diff  [hpm_pkg::LANES];
  logic                    ge    [hpm_pkg::LANES];

  always_comb begin
    lanes_nxt = lanes_i;
    for (int i = 0; i < hpm_pkg::LANES; i++) begin
      trial[i] = {lanes_i[i].rem, lanes_i[i].nq[hpm_pkg::NUM_W-1]};
      diff[i]  = trial[i] - {1'b0, lanes_i[i].den};
      ge[i]    = trial[i] >= {1'b0, lanes_i[i].den};
      lanes_nxt[i].rem = ge[i] ? diff[i][hpm_pkg::SUM_W-1:0] : trial[i][hpm_pkg::SUM_W-1:0];
      lanes_nxt[i].nq  = {lanes_i[i].nq[hpm_pkg::NUM_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ce) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side_r  <= side_i;
      lanes_r <= lanes_nxt;
    end
  end

  assign valid_o = v_r;
  assign side_o  = side_r;
  assign lanes_o = lanes_r;

endmodule

[design/hpm_back.sv]
// back stages: quotient signs, displacement difference, saturation, output register
module hpm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ce,
  input  logic                  valid_i,
  input  hpm_pkg::side_t        side_i,
  input  hpm_pkg::lane_arr_t    lanes_i,
  output logic                  valid_o,
  output hpm_pkg::coord_t       x_o,
  output hpm_pkg::coord_t       y_o,
  output logic                  inf_o,
  output logic                  sat_o
);

  logic            b1v_r, b2v_r, ov_r;
  hpm_pkg::side_t  b1s_r, b2s_r;
  hpm_pkg::qs_t    q_r [hpm_pkg::LANES];
  hpm_pkg::qs_t    q_nxt [hpm_pkg::LANES];
  hpm_pkg::diff_t  dx_r, dy_r, dx_nxt, dy_nxt;
  hpm_pkg::coord_t ox_r, oy_r, ox_nxt, oy_nxt;
  logic            oinf_r, osat_r, oinf_nxt, osat_nxt;
  hpm_pkg::sat_t   sx, sy;

  always_comb begin
    for (int i = 0; i < hpm_pkg::LANES; i++) begin
      q_nxt[i] = hpm_pkg::qs_t'({1'b0, lanes_i[i].nq});
      if (lanes_i[i].neg) begin
        q_nxt[i] = -q_nxt[i];
      end
    end
  end

  always_comb begin
    dx_nxt = hpm_pkg::diff_t'(q_r[hpm_pkg::LANE_X1]);
    dy_nxt = hpm_pkg::diff_t'(q_r[hpm_pkg::LANE_Y1]);
    if (b1s_r.func) begin
      dx_nxt = dx_nxt - hpm_pkg::diff_t'(q_r[hpm_pkg::LANE_X2]);
      dy_nxt = dy_nxt - hpm_pkg::diff_t'(q_r[hpm_pkg::LANE_Y2]);
    end
  end

  always_comb begin
    sx       = hpm_pkg::sat_coord(dx_r);
    sy       = hpm_pkg::sat_coord(dy_r);
    ox_nxt   = b2s_r.rx;
    oy_nxt   = b2s_r.ry;
    oinf_nxt = 1'b0;
    osat_nxt = b2s_r.rsat;
    if (b2s_r.form == hpm_pkg::FORM_PROJ) begin
      if (b2s_r.inf) begin
        ox_nxt   = hpm_pkg::COORD_MAX;
        oy_nxt   = hpm_pkg::COORD_MAX;
        oinf_nxt = 1'b1;
        osat_nxt = 1'b1;
      end else begin
        ox_nxt   = sx.val;
        oy_nxt   = sy.val;
        osat_nxt = sx.flag || sy.flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1v_r <= 1'b0;
      b2v_r <= 1'b0;
      ov_r  <= 1'b0;
    end else if (ce) begin
      b1v_r <= valid_i;
      b2v_r <= b1v_r;
      ov_r  <= b2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      b1s_r  <= side_i;
      q_r    <= q_nxt;
      b2s_r  <= b1s_r;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oinf_r <= oinf_nxt;
      osat_r <= osat_nxt;
    end
  end

  assign valid_o = ov_r;
  assign x_o     = ox_r;
  assign y_o     = oy_r;
  assign inf_o   = oinf_r;
  assign sat_o   = osat_r;

endmodule

[design/homography_point_map_2d.sv]
// top level of the 2d point mapper: config registers, pipeline and stream ports
// pipeline: 4 front stages, 97 one-bit restoring division steps and 3 back
//   stages lie between an input transfer and out_tvalid
// throughput: one item per cycle; the whole pipeline advances together and
//   holds when the output register is full and out_tready is low
// reset: synchronous active-low rst_n clears all valid bits and loads the
//   identity transform; payload registers are not reset
module homography_point_map_2d (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hpm_pkg::IN_DATA_W-1:0]      in_tdata,   // in_x, in_y, in_dx, in_dy
  input  logic [0:0]                         in_tuser,   // func
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hpm_pkg::OUT_DATA_W-1:0]     out_tdata,  // out_x, out_y
  output logic [1:0]                         out_tuser,  // at_infinity, saturated
  // configuration write port
  input  logic                               cfg_we,
  input  logic [hpm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [hpm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = hpm_pkg::COORD_W;

  hpm_pkg::cfg_t cfg_r;
  logic          ce;

  // pipeline advances whenever the output register can take a new value
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.form    <= hpm_pkg::FORM_IDENT;
      cfg_r.lin_xx  <= hpm_pkg::coef_t'(32'sd65536);
      cfg_r.lin_xy  <= '0;
      cfg_r.lin_yx  <= '0;
      cfg_r.lin_yy  <= hpm_pkg::coef_t'(32'sd65536);
      cfg_r.off_x   <= '0;
      cfg_r.off_y   <= '0;
      cfg_r.persp_g <= '0;
      cfg_r.persp_h <= '0;
      cfg_r.persp_w <= hpm_pkg::coef_t'(32'sd65536);
    end else if (cfg_we) begin
      case (hpm_pkg::cfg_idx_t'(cfg_idx))
        hpm_pkg::CFG_FORM:    cfg_r.form   <= hpm_pkg::form_t'(cfg_data[2:0]);
        hpm_pkg::CFG_LIN_XX:  cfg_r.lin_xx <= hpm_pkg::coef_t'(cfg_data[31:0]);
        hpm_pkg::CFG_LIN_XY:  cfg_r.lin_xy <= hpm_pkg::coef_t'(cfg_data[31:0]);
        hpm_pkg::CFG_LIN_YX:  cfg_r.lin_yx <= hpm_pkg::coef_t'(cfg_data[31:0]);
        hpm_pkg::CFG_LIN_YY:  cfg_r.lin_yy <= hpm_pkg::coef_t'(cfg_data[31:0]);
        hpm_pkg::CFG_OFFSET: begin
          cfg_r.off_x <= hpm_pkg::coef_t'(cfg_data[63:32]);
          cfg_r.off_y <= hpm_pkg::coef_t'(cfg_data[31:0]);
        end
        hpm_pkg::CFG_PERSP: begin
          cfg_r.persp_g <= hpm_pkg::coef_t'(cfg_data[63:32]);
          cfg_r.persp_h <= hpm_pkg::coef_t'(cfg_data[31:0]);
        end
        hpm_pkg::CFG_PERSP_W: cfg_r.persp_w <= hpm_pkg::coef_t'(cfg_data[31:0]);
        default: ;
      endcase
    end
  end

  // front: point select, products, sums, divider operands
  logic               fv;
  hpm_pkg::side_t     fside;
  hpm_pkg::lane_arr_t flanes;

  hpm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .valid_i (in_tvalid && in_tready),
    .func_i  (in_tuser[0]),
    .x_i     (hpm_pkg::coord_t'(in_tdata[CW-1:0])),
    .y_i     (hpm_pkg::coord_t'(in_tdata[2*CW-1:CW])),
    .dx_i    (hpm_pkg::coord_t'(in_tdata[3*CW-1:2*CW])),
    .dy_i    (hpm_pkg::coord_t'(in_tdata[4*CW-1:3*CW])),
    .cfg_i   (cfg_r),
    .valid_o (fv),
    .side_o  (fside),
    .lanes_o (flanes)
  );

  // divider chain, one quotient bit per stage for all four lanes
  logic               dv     [hpm_pkg::DIV_STEPS+1];
  hpm_pkg::side_t     dside  [hpm_pkg::DIV_STEPS+1];
  hpm_pkg::lane_arr_t dlanes [hpm_pkg::DIV_STEPS+1];

  assign dv[0]     = fv;
  assign dside[0]  = fside;
  assign dlanes[0] = flanes;

  for (genvar i = 0; i < hpm_pkg::DIV_STEPS; i++) begin : g_div
    hpm_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .ce      (ce),
      .valid_i (dv[i]),
      .side_i  (dside[i]),
      .lanes_i (dlanes[i]),
      .valid_o (dv[i+1]),
      .side_o  (dside[i+1]),
      .lanes_o (dlanes[i+1])
    );
  end

  // back: signed quotients, displacement difference, saturation
  hpm_pkg::coord_t ox, oy;
  logic            oinf, osat;

  hpm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .valid_i (dv[hpm_pkg::DIV_STEPS]),
    .side_i  (dside[hpm_pkg::DIV_STEPS]),
    .lanes_i (dlanes[hpm_pkg::DIV_STEPS]),
    .valid_o (out_tvalid),
    .x_o     (ox),
    .y_o     (oy),
    .inf_o   (oinf),
    .sat_o   (osat)
  );

  assign out_tdata = {oy, ox};
  assign out_tuser = {osat, oinf};

endmodule

[design/hpm_chk.sv]
// port-level checker for the 2d point mapper, bound to the top level
module hpm_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [hpm_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser
);

  localparam int CW = hpm_pkg::COORD_W;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // input is taken exactly when the output side can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  // infinity always comes with the saturated flag
  a_inf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[1])
    else $error("at_infinity without saturated");

  // infinity gives the largest positive coordinates
  a_inf_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[CW-1:0] == hpm_pkg::COORD_MAX && out_tdata[2*CW-1:CW] == hpm_pkg::COORD_MAX)
    else $error("at_infinity result not at maximum");

endmodule

bind homography_point_map_2d hpm_chk u_hpm_chk (.*);

[dv/testbench.sv]
// self-checking testbench for the 2d homography point mapper
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [127:0] wide_t;

  // one mapped point as it should leave the block
  typedef struct {
    hpm_pkg::coord_t px;
    hpm_pkg::coord_t py;
    bit              inf;
    bit              sat;
  } mapped_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [hpm_pkg::IN_DATA_W-1:0]    in_tdata;   // in_x, in_y, in_dx, in_dy
  logic [0:0]                       in_tuser;   // func
  logic                             out_tvalid;
  logic                             out_tready;
  logic [hpm_pkg::OUT_DATA_W-1:0]   out_tdata;  // out_x, out_y
  logic [1:0]                       out_tuser;  // at_infinity, saturated
  logic                             cfg_we;
  logic [hpm_pkg::CFG_IDX_W-1:0]    cfg_idx;
  logic [hpm_pkg::CFG_DATA_W-1:0]   cfg_data;

  homography_point_map_2d DUT (.*);

  // mirror of the transform registers
  hpm_pkg::form_t m_form;
  hpm_pkg::coef_t m_xx, m_xy, m_yx, m_yy, m_offx, m_offy, m_g, m_h, m_w;

  mapped_t expected_points[$];
  int      fail_cnt;
  int      hold_cycles;   // receiver hold-off request, counted down by the receiver

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic hpm_pkg::coord_t clamp_coord(input wide_t v, inout bit flag);
    if (v > wide_t'(hpm_pkg::COORD_MAX)) begin
      flag = 1'b1;
      return hpm_pkg::COORD_MAX;
    end
    if (v < wide_t'(hpm_pkg::COORD_MIN)) begin
      flag = 1'b1;
      return hpm_pkg::COORD_MIN;
    end
    return hpm_pkg::coord_t'(v);
  endfunction

  // projective map of one point; returns 1 when w comes out zero
  function automatic bit proj_map(input wide_t x, input wide_t y,
                                  output wide_t qx, output wide_t qy);
    wide_t z, nx, ny;
    z  = x * wide_t'(m_g) + y * wide_t'(m_h) + (wide_t'(m_w) <<< hpm_pkg::PERSP_FRAC);
    qx = '0;
    qy = '0;
    if (z == 0) return 1'b1;
    nx = x * wide_t'(m_xx) + y * wide_t'(m_xy) + (wide_t'(m_offx) <<< hpm_pkg::FRAC_W);
    ny = x * wide_t'(m_yx) + y * wide_t'(m_yy) + (wide_t'(m_offy) <<< hpm_pkg::FRAC_W);
    qx = (nx <<< hpm_pkg::PERSP_FRAC) / z;   // truncates toward zero
    qy = (ny <<< hpm_pkg::PERSP_FRAC) / z;
    return 1'b0;
  endfunction

  function automatic mapped_t map_point(input bit func,
                                        input hpm_pkg::coord_t x, input hpm_pkg::coord_t y,
                                        input hpm_pkg::coord_t dx, input hpm_pkg::coord_t dy);
    mapped_t r;
    wide_t   u, v, rx, ry, ax, ay, bx, by;
    bit      flag;
    flag = 1'b0;
    r.px = '0;
    r.py = '0;
    r.inf = 1'b0;
    u = func ? wide_t'(dx) : wide_t'(x);
    v = func ? wide_t'(dy) : wide_t'(y);
    case (m_form)
      hpm_pkg::FORM_IDENT: begin
        r.px = hpm_pkg::coord_t'(u);
        r.py = hpm_pkg::coord_t'(v);
      end
      hpm_pkg::FORM_TRANS: begin
        if (func) begin
          r.px = dx;
          r.py = dy;
        end else begin
          r.px = clamp_coord(u + wide_t'(m_offx), flag);
          r.py = clamp_coord(v + wide_t'(m_offy), flag);
        end
      end
      hpm_pkg::FORM_RIGID, hpm_pkg::FORM_AFFINE: begin
        rx = u * wide_t'(m_xx) + v * wide_t'(m_xy);
        ry = u * wide_t'(m_yx) + v * wide_t'(m_yy);
        if (!func) begin
          rx = rx + (wide_t'(m_offx) <<< hpm_pkg::FRAC_W);
          ry = ry + (wide_t'(m_offy) <<< hpm_pkg::FRAC_W);
        end
        r.px = clamp_coord(rx >>> hpm_pkg::FRAC_W, flag);
        r.py = clamp_coord(ry >>> hpm_pkg::FRAC_W, flag);
      end
      hpm_pkg::FORM_PROJ: begin
        if (!func) begin
          r.inf = proj_map(wide_t'(x), wide_t'(y), rx, ry);
        end else begin
          r.inf = proj_map(wide_t'(x) + wide_t'(dx), wide_t'(y) + wide_t'(dy), ax, ay);
          r.inf = proj_map(wide_t'(x), wide_t'(y), bx, by) | r.inf;
          rx = ax - bx;
          ry = ay - by;
        end
        if (!r.inf) begin
          r.px = clamp_coord(rx, flag);
          r.py = clamp_coord(ry, flag);
        end
      end
      default: ;
    endcase
    if (r.inf) begin
      r.px = hpm_pkg::COORD_MAX;
      r.py = hpm_pkg::COORD_MAX;
      flag = 1'b1;
    end
    r.sat = flag;
    return r;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    mapped_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        $error("result transfer with no point pending: %h", out_tdata);
        fail_cnt++;
      end else begin
        e = expected_points.pop_front();
        if (hpm_pkg::coord_t'(out_tdata[31:0]) !== e.px) begin
          $error("out_x expected %0d actual %0d", e.px, hpm_pkg::coord_t'(out_tdata[31:0]));
          fail_cnt++;
        end
        if (hpm_pkg::coord_t'(out_tdata[63:32]) !== e.py) begin
          $error("out_y expected %0d actual %0d", e.py, hpm_pkg::coord_t'(out_tdata[63:32]));
          fail_cnt++;
        end
        if (out_tuser[0] !== e.inf) begin
          $error("at_infinity expected %0d actual %0d", e.inf, out_tuser[0]);
          fail_cnt++;
        end
        if (out_tuser[1] !== e.sat) begin
          $error("saturated expected %0d actual %0d", e.sat, out_tuser[1]);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // stall pattern is redrawn each time rx_tick wraps: always ready, mostly ready
  // and mostly stalled; a hold-off request overrides it
  int rx_mode, rx_tick;
  always @(posedge clk) begin
    if (rx_tick == 0) rx_mode <= $urandom_range(0, 2);
    rx_tick <= (rx_tick + 1) % 64;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- helpers
  task automatic write_reg(input hpm_pkg::cfg_idx_t idx, input logic [63:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hpm_pkg::CFG_FORM:    m_form = hpm_pkg::form_t'(data[2:0]);
      hpm_pkg::CFG_LIN_XX:  m_xx = data[31:0];
      hpm_pkg::CFG_LIN_XY:  m_xy = data[31:0];
      hpm_pkg::CFG_LIN_YX:  m_yx = data[31:0];
      hpm_pkg::CFG_LIN_YY:  m_yy = data[31:0];
      hpm_pkg::CFG_OFFSET:  {m_offx, m_offy} = data;
      hpm_pkg::CFG_PERSP:   {m_g, m_h} = data;
      hpm_pkg::CFG_PERSP_W: m_w = data[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one point transfer; valid stays high for a following item
  task automatic send_point(input bit func, input hpm_pkg::coord_t x, input hpm_pkg::coord_t y,
                            input hpm_pkg::coord_t dx, input hpm_pkg::coord_t dy);
    in_tvalid <= 1'b1;
    in_tdata  <= {dy, dx, y, x};
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
    expected_points.push_back(map_point(func, x, y, dx, dy));
  endtask

  task automatic pause_input(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait until every pending point has come back
  task automatic drain();
    pause_input(1);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic hpm_pkg::coord_t rand_coord();
    case ($urandom_range(0, 5))
      0:       return hpm_pkg::COORD_MAX;
      1:       return hpm_pkg::COORD_MIN;
      2:       return hpm_pkg::coord_t'($urandom);
      3:       return '0;
      default: return hpm_pkg::coord_t'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  // bursty sender of random points
  task automatic random_points(input int n);
    for (int i = 0; i < n; i++) begin
      send_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord());
      if ($urandom_range(0, 7) == 0) pause_input($urandom_range(1, 12));
    end
    drain();
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_identity();
    write_reg(hpm_pkg::CFG_FORM, 64'(hpm_pkg::FORM_IDENT));
    send_point(1'b0, hpm_pkg::COORD_MAX, hpm_pkg::COORD_MIN, 32'sd5, -32'sd5);
    send_point(1'b1, 32'sd1, 32'sd2, hpm_pkg::COORD_MIN, hpm_pkg::COORD_MAX);
    send_point(1'b0, '0, '0, '0, '0);
    drain();
  endtask

  task automatic test_translation();
    write_reg(hpm_pkg::CFG_OFFSET, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(hpm_pkg::CFG_FORM, 64'(hpm_pkg::FORM_TRANS));
    send_point(1'b0, hpm_pkg::COORD_MAX, hpm_pkg::COORD_MIN, '0, '0);     // both clamp
    send_point(1'b0, hpm_pkg::COORD_MIN, hpm_pkg::COORD_MAX, '0, '0);
    // displacement passes
    send_point(1'b1, hpm_pkg::COORD_MAX, hpm_pkg::COORD_MAX, 32'sd7, -32'sd9);
    drain();
  endtask

  task automatic test_linear();
    write_reg(hpm_pkg::CFG_LIN_XX, 64'(32'h8000_0000));
    write_reg(hpm_pkg::CFG_LIN_XY, 64'(32'h7FFF_FFFF));
    write_reg(hpm_pkg::CFG_LIN_YX, 64'(32'h0000_8000));
    write_reg(hpm_pkg::CFG_LIN_YY, 64'(32'hFFFF_0000));
    write_reg(hpm_pkg::CFG_OFFSET, {32'h0001_0000, 32'hFFFF_8000});
    write_reg(hpm_pkg::CFG_FORM, 64'(hpm_pkg::FORM_RIGID));
    send_point(1'b0, hpm_pkg::COORD_MIN, hpm_pkg::COORD_MIN, '0, '0);
    send_point(1'b0, -32'sd1, 32'sd3, '0, '0);          // rounds toward minus infinity
    send_point(1'b1, 32'sd100, 32'sd100, hpm_pkg::COORD_MAX, -32'sd1);
    drain();
    write_reg(hpm_pkg::CFG_FORM, 64'(hpm_pkg::FORM_AFFINE));
    send_point(1'b0, 32'sd65536, -32'sd65536, '0, '0);
    send_point(1'b1, '0, '0, hpm_pkg::COORD_MIN, hpm_pkg::COORD_MAX);
    drain();
  endtask

  task automatic test_projective();
    write_reg(hpm_pkg::CFG_LIN_XX, 64'(32'h0001_0000));
    write_reg(hpm_pkg::CFG_LIN_XY, 64'(32'h0000_0000));
    write_reg(hpm_pkg::CFG_LIN_YX, 64'(32'h0000_0000));
    write_reg(hpm_pkg::CFG_LIN_YY, 64'(32'h0001_0000));
    write_reg(hpm_pkg::CFG_OFFSET, 64'd0);
    write_reg(hpm_pkg::CFG_PERSP, {32'h4000_0000, 32'h0000_0000}); // w = x + 0
    write_reg(hpm_pkg::CFG_PERSP_W, 64'(32'd0));
    write_reg(hpm_pkg::CFG_FORM, 64'(hpm_pkg::FORM_PROJ));
    send_point(1'b0, '0, 32'sd5, '0, '0);                 // zero denominator
    send_point(1'b0, 32'sd65536, 32'sd131072, '0, '0);
    send_point(1'b1, 32'sd65536, 32'sd1, -32'sd65536, '0); // first point at infinity
    send_point(1'b1, '0, 32'sd1, 32'sd65536, '0);          // second point at infinity
    send_point(1'b1, 32'sd1, hpm_pkg::COORD_MAX, 32'sd2, hpm_pkg::COORD_MIN);
    send_point(1'b0, 32'sd1, hpm_pkg::COORD_MAX, '0, '0);  // large quotient clamps
    drain();
    write_reg(hpm_pkg::CFG_PERSP, 64'd0);
    write_reg(hpm_pkg::CFG_PERSP_W, 64'(32'h0001_0000));
    send_point(1'b0, -32'sd3, 32'sd7, '0, '0);
    send_point(1'b1, hpm_pkg::COORD_MIN, hpm_pkg::COORD_MAX,
               hpm_pkg::COORD_MIN, hpm_pkg::COORD_MAX);
    drain();
  endtask

  // several random settings, each with a burst of random points
  task automatic test_random_settings();
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(hpm_pkg::CFG_LIN_XX, 64'(rand_coef()));
      write_reg(hpm_pkg::CFG_LIN_XY, 64'(rand_coef()));
      write_reg(hpm_pkg::CFG_LIN_YX, 64'(rand_coef()));
      write_reg(hpm_pkg::CFG_LIN_YY, 64'(rand_coef()));
      write_reg(hpm_pkg::CFG_OFFSET, {rand_coef(), rand_coef()});
      write_reg(hpm_pkg::CFG_PERSP, ($urandom_range(0, 1) != 0) ?
                {$urandom, $urandom} :
                {32'($urandom_range(0, 255)), 32'($urandom_range(0, 255))});
      write_reg(hpm_pkg::CFG_PERSP_W,
                64'(($urandom_range(0, 3) == 0) ? 32'd0 : rand_coef()));
      write_reg(hpm_pkg::CFG_FORM, 64'(hpm_pkg::form_t'(ph % 5)));
      random_points(90);
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_backpressure();
    write_reg(hpm_pkg::CFG_FORM, 64'(hpm_pkg::FORM_AFFINE));
    hold_cycles = 400;
    for (int i = 0; i < 150; i++)
      send_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord());
    drain();
  endtask

  initial begin
    fail_cnt    = 0;
    hold_cycles = 0;
    rx_tick     = 0;
    rx_mode     = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = hpm_pkg::CFG_FORM;
    cfg_data   = '0;
    // reset values of the transform
    m_form = hpm_pkg::FORM_IDENT;
    m_xx = 32'sd65536; m_xy = '0; m_yx = '0; m_yy = 32'sd65536;
    m_offx = '0; m_offy = '0; m_g = '0; m_h = '0; m_w = 32'sd65536;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity();
    test_translation();
    test_linear();
    test_projective();
    test_random_settings();
    test_backpressure();

    repeat (110) @(posedge clk);
    if (fail_cnt == 0 && expected_points.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
